// ----- hdl/vcal_pkg.sv -----
`timescale 1ns / 1ps
package vcal_pkg;

  localparam int QDEPTH = 4;
  localparam int ZW = 48;
  localparam int VW = 36;
  localparam int CORDIC_STEPS = 30;
  localparam int MOD_STEPS = 10;

  localparam logic signed [ZW-1:0] TWO_PI_Q30  = 48'sd6746518852;
  localparam logic signed [ZW-1:0] PI_Q30      = 48'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 48'sd1686629713;
  localparam logic signed [30:0]   CORDIC_GAIN = 31'sd652032874;

  localparam logic [2:0] CFG_MAX_SPEED      = 3'd0;
  localparam logic [2:0] CFG_MAX_TURN_RATE  = 3'd1;
  localparam logic [2:0] CFG_MAX_ACCEL      = 3'd2;
  localparam logic [2:0] CFG_MAX_TURN_ACCEL = 3'd3;
  localparam logic [2:0] CFG_UPDATE_PERIOD  = 3'd4;
  localparam logic [2:0] CFG_KICK_THRESHOLD = 3'd5;

  typedef struct packed {
    logic [30:0] max_speed;
    logic [30:0] max_turn_rate;
    logic [30:0] max_accel;
    logic [30:0] max_turn_accel;
    logic [16:0] update_period;
    logic [14:0] kick_threshold;
  } vcal_cfg_t;

  typedef struct packed {
    logic signed [31:0]   target_vx;
    logic signed [31:0]   target_vy;
    logic signed [31:0]   target_turn;
    logic signed [31:0]   measured_vx;
    logic signed [31:0]   measured_vy;
    logic signed [31:0]   measured_turn;
    logic signed [ZW-1:0] z;
    logic                 flat;
    logic                 chip;
  } vcal_item_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MOD, ST_WRAP, ST_CORD, ST_GAINX, ST_GAINY, ST_TCLAMP,
    ST_VSH, ST_SQA, ST_SQB, ST_SQGO, ST_SQW, ST_CMP, ST_SMUL, ST_SDGO,
    ST_SDW, ST_PDGO, ST_PDW, ST_DIFF, ST_LIMT, ST_LIMR, ST_TURN,
    ST_TDGO, ST_TDW, ST_DONE
  } vcal_state_t;

  function automatic logic [ZW-1:0] atan_q30(input logic [4:0] i);
    logic [ZW-1:0] a;
    case (i)
      5'd0:    a = 48'd843314857;
      5'd1:    a = 48'd497837829;
      5'd2:    a = 48'd263043837;
      5'd3:    a = 48'd133525159;
      5'd4:    a = 48'd67021687;
      5'd5:    a = 48'd33543516;
      5'd6:    a = 48'd16775851;
      5'd7:    a = 48'd8388437;
      5'd8:    a = 48'd4194283;
      5'd9:    a = 48'd2097149;
      5'd10:   a = 48'd1048576;
      default: a = 48'd1 << (5'd30 - i);
    endcase
    return a;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // smallest right shift that brings both magnitudes below 2^31
  function automatic logic [2:0] norm_shift(input logic [VW-2:0] o);
    logic [2:0] s;
    s = 3'd0;
    for (int k = 31; k < VW - 1; k++) begin
      if (o[k]) s = 3'(k - 30);
    end
    return s;
  endfunction

endpackage

// ----- hdl/vcal_div.sv -----
`timescale 1ns / 1ps
module vcal_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [63:0] quot
);
  logic [63:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt, dvs_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt, done_r, done_nxt;
  logic [33:0] rem_sh;

  always_comb begin
    rem_sh   = {rem_r, q_r[63]};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = 33'(rem_sh - {1'b0, dvs_r});
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[32:0];
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) dvs_r <= divisor;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

// ----- hdl/vcal_isqrt.sv -----
`timescale 1ns / 1ps
module vcal_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] value,
  output logic        done,
  output logic [31:0] root
);
  logic [63:0] v_r, v_nxt, r_r, r_nxt, b, rb;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt, done_r, done_nxt;

  always_comb begin
    b        = 64'h4000_0000_0000_0000 >> {cnt_r, 1'b0};
    rb       = r_r + b;
    v_nxt    = v_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      v_nxt   = value;
      r_nxt   = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (v_r >= rb) begin
        v_nxt = v_r - rb;
        r_nxt = (r_r >> 1) + b;
      end else begin
        r_nxt = r_r >> 1;
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    r_r   <= r_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign root = r_r[31:0];
endmodule

// ----- hdl/vcal_front.sv -----
`timescale 1ns / 1ps
module vcal_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  in_target_vx,
  input  logic signed [31:0]  in_target_vy,
  input  logic signed [31:0]  in_target_turn,
  input  logic signed [31:0]  in_measured_vx,
  input  logic signed [31:0]  in_measured_vy,
  input  logic signed [31:0]  in_measured_turn,
  input  logic signed [18:0]  in_heading,
  input  logic signed [15:0]  in_flat_trigger,
  input  logic signed [15:0]  in_chip_trigger,
  input  logic [14:0]         kick_threshold,
  input  logic                pop,
  output logic                q_valid,
  output vcal_pkg::vcal_item_t q_item
);
  import vcal_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  vcal_item_t        mem_r [QDEPTH];
  vcal_item_t        item;
  logic [PW-1:0]     wp_r, rp_r;
  logic [CW-1:0]     cnt_r;
  logic              push;
  logic signed [ZW-1:0] zext;

  always_comb begin
    zext = {{(ZW-19){in_heading[18]}}, in_heading};
    item.target_vx     = in_target_vx;
    item.target_vy     = in_target_vy;
    item.target_turn   = in_target_turn;
    item.measured_vx   = in_measured_vx;
    item.measured_vy   = in_measured_vy;
    item.measured_turn = in_measured_turn;
    item.z             = zext <<< (30 - FRAC_BITS);
    item.flat = in_flat_trigger > $signed({1'b0, kick_threshold});
    item.chip = !item.flat && (in_chip_trigger > $signed({1'b0, kick_threshold}));
  end

  assign busy    = (cnt_r == CW'(QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= item;
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= PW'(wp_r + 1'b1);
      if (pop && q_valid) rp_r <= PW'(rp_r + 1'b1);
      cnt_r <= CW'(cnt_r + CW'(push) - CW'(pop && q_valid));
    end
  end
endmodule

// ----- hdl/vcal_back.sv -----
`timescale 1ns / 1ps
module vcal_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vcal_pkg::vcal_cfg_t  cfg,
  input  logic                 q_valid,
  input  vcal_pkg::vcal_item_t q_item,
  output logic                 pop,
  output logic                 out_valid,
  output logic signed [31:0]   out_accel_x,
  output logic signed [31:0]   out_accel_y,
  output logic signed [31:0]   out_accel_turn,
  output logic                 out_kick_flat,
  output logic                 out_kick_chip
);
  import vcal_pkg::*;

  vcal_state_t state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic signed [VW-1:0] x_r, x_nxt, y_r, y_nxt, tx_r, tx_nxt, ty_r, ty_nxt;
  logic signed [VW-1:0] tt_r, tt_nxt, mt_r, mt_nxt, va_r, va_nxt, vb_r, vb_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic [63:0] acc_r, acc_nxt, lim_r, lim_nxt;
  logic [30:0] as_r, as_nxt, bs_r, bs_nxt;
  logic [2:0]  s_r, s_nxt;
  logic [31:0] n_r, n_nxt;
  logic        phase_r, phase_nxt, sel_r, sel_nxt, flat_r, flat_nxt, chip_r, chip_nxt;
  logic signed [31:0] ax_r, ax_nxt, ay_r, ay_nxt, at_r, at_nxt;
  logic        ov_r;
  logic signed [31:0] ox_r, oy_r, ot_r;
  logic        of_r, oc_r;

  logic        div_go, div_done, sq_go, sq_done;
  logic [63:0] div_dvd, div_q;
  logic [32:0] div_dvs;
  logic [31:0] sq_root;

  logic signed [VW-1:0] vsel, qv;
  logic [VW-2:0] a_abs, b_abs, v_abs;
  logic [ZW-1:0] tw, uabs;
  logic signed [ZW-1:0] m, ang;
  logic signed [VW+30:0] gprod, grnd;
  logic signed [63:0] sval;
  logic [30:0] scale_lim;

  vcal_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go), .dividend(div_dvd),
    .divisor(div_dvs), .done(div_done), .quot(div_q)
  );

  vcal_isqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_go), .value(acc_r),
    .done(sq_done), .root(sq_root)
  );

  always_comb begin
    vsel  = sel_r ? vb_r : va_r;
    a_abs = va_r[VW-1] ? (VW-1)'(-va_r) : va_r[VW-2:0];
    b_abs = vb_r[VW-1] ? (VW-1)'(-vb_r) : vb_r[VW-2:0];
    v_abs = vsel[VW-1] ? (VW-1)'(-vsel) : vsel[VW-2:0];
    scale_lim = phase_r ? cfg.max_accel : cfg.max_speed;
    div_go  = (state_r == ST_SDGO) || (state_r == ST_PDGO) || (state_r == ST_TDGO);
    div_dvd = (state_r == ST_SDGO) ? acc_r : ({29'd0, v_abs} << FRAC_BITS);
    div_dvs = (state_r == ST_SDGO) ? {1'b0, n_r} : {16'd0, cfg.update_period};
    sq_go   = (state_r == ST_SQGO);
    pop     = (state_r == ST_IDLE) && q_valid;
    tw      = ZW'(TWO_PI_Q30) << cnt_r;
    uabs    = z_r[ZW-1] ? ZW'(-z_r) : ZW'(z_r);
    m       = '0;
    ang     = $signed(atan_q30(cnt_r));
    gprod   = (sel_r ? y_r : x_r) * CORDIC_GAIN;
    grnd    = gprod + ((VW+31)'(1) <<< 29);
    qv      = vsel[VW-1] ? -$signed(VW'(div_q[31:0])) : $signed(VW'(div_q[31:0]));
    sval    = vsel[VW-1] ? -$signed(div_q) : $signed(div_q);

    state_nxt = state_r;
    cnt_nxt = cnt_r;
    x_nxt = x_r;   y_nxt = y_r;   z_nxt = z_r;
    tx_nxt = tx_r; ty_nxt = ty_r; tt_nxt = tt_r; mt_nxt = mt_r;
    va_nxt = va_r; vb_nxt = vb_r;
    acc_nxt = acc_r; lim_nxt = lim_r;
    as_nxt = as_r; bs_nxt = bs_r; s_nxt = s_r; n_nxt = n_r;
    phase_nxt = phase_r; sel_nxt = sel_r;
    flat_nxt = flat_r; chip_nxt = chip_r;
    ax_nxt = ax_r; ay_nxt = ay_r; at_nxt = at_r;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          x_nxt  = VW'(q_item.measured_vx);
          y_nxt  = VW'(q_item.measured_vy);
          mt_nxt = VW'(q_item.measured_turn);
          tx_nxt = VW'(q_item.target_vx);
          ty_nxt = VW'(q_item.target_vy);
          tt_nxt = VW'(q_item.target_turn);
          z_nxt  = q_item.z;
          flat_nxt = q_item.flat;
          chip_nxt = q_item.chip;
          cnt_nxt  = 5'(MOD_STEPS - 1);
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        // |z| mod 2pi by restoring subtraction
        if (cnt_r == 5'(MOD_STEPS - 1)) acc_nxt = 64'(uabs);
        if (((cnt_r == 5'(MOD_STEPS - 1)) ? 64'(uabs) : acc_r) >= 64'(tw))
          acc_nxt = ((cnt_r == 5'(MOD_STEPS - 1)) ? 64'(uabs) : acc_r) - 64'(tw);
        if (cnt_r == '0) state_nxt = ST_WRAP;
        else cnt_nxt = cnt_r - 5'd1;
      end
      ST_WRAP: begin
        m = $signed(acc_r[ZW-1:0]);
        if (z_r[ZW-1] && m != '0) m = TWO_PI_Q30 - m;
        if (m > PI_Q30) m = m - TWO_PI_Q30;
        if (m > HALF_PI_Q30) begin
          x_nxt = -y_r; y_nxt = x_r; m = m - HALF_PI_Q30;
        end else if (m < -HALF_PI_Q30) begin
          x_nxt = y_r; y_nxt = -x_r; m = m + HALF_PI_Q30;
        end
        z_nxt = m;
        cnt_nxt = '0;
        state_nxt = ST_CORD;
      end
      ST_CORD: begin
        if (!z_r[ZW-1]) begin
          x_nxt = x_r - (y_r >>> cnt_r);
          y_nxt = y_r + (x_r >>> cnt_r);
          z_nxt = z_r - ang;
        end else begin
          x_nxt = x_r + (y_r >>> cnt_r);
          y_nxt = y_r - (x_r >>> cnt_r);
          z_nxt = z_r + ang;
        end
        if (cnt_r == 5'(CORDIC_STEPS - 1)) begin
          sel_nxt = 1'b0;
          state_nxt = ST_GAINX;
        end else cnt_nxt = cnt_r + 5'd1;
      end
      ST_GAINX: begin
        x_nxt = VW'(grnd >>> 30);
        sel_nxt = 1'b1;
        state_nxt = ST_GAINY;
      end
      ST_GAINY: begin
        y_nxt = VW'(grnd >>> 30);
        state_nxt = ST_TCLAMP;
      end
      ST_TCLAMP: begin
        if ((tt_r[VW-1] ? (VW-1)'(-tt_r) : tt_r[VW-2:0]) > (VW-1)'(cfg.max_turn_rate))
          tt_nxt = tt_r[VW-1] ? -$signed(VW'(cfg.max_turn_rate))
                              : $signed(VW'(cfg.max_turn_rate));
        va_nxt = tx_r;
        vb_nxt = ty_r;
        phase_nxt = 1'b0;
        state_nxt = ST_VSH;
      end
      ST_VSH: begin
        s_nxt  = norm_shift(a_abs | b_abs);
        as_nxt = 31'(a_abs >> norm_shift(a_abs | b_abs));
        bs_nxt = 31'(b_abs >> norm_shift(a_abs | b_abs));
        state_nxt = ST_SQA;
      end
      ST_SQA: begin
        acc_nxt = 64'(as_r) * 64'(as_r);
        state_nxt = ST_SQB;
      end
      ST_SQB: begin
        acc_nxt = acc_r + 64'(bs_r) * 64'(bs_r);
        state_nxt = ST_SQGO;
      end
      ST_SQGO: state_nxt = ST_SQW;
      ST_SQW: begin
        if (sq_done) begin
          n_nxt = sq_root;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        sel_nxt = 1'b0;
        if ((64'(n_r) << s_r) > (phase_r ? lim_r : 64'(cfg.max_speed)))
          state_nxt = ST_SMUL;
        else if (!phase_r) state_nxt = ST_DIFF;
        else state_nxt = ST_PDGO;
      end
      ST_SMUL: begin
        acc_nxt = 64'(sel_r ? bs_r : as_r) * 64'(scale_lim);
        state_nxt = ST_SDGO;
      end
      ST_SDGO: state_nxt = ST_SDW;
      ST_SDW: begin
        if (div_done) begin
          if (!phase_r) begin
            if (sel_r) ty_nxt = qv; else tx_nxt = qv;
          end else begin
            if (sel_r) ay_nxt = sat32(64'(qv)); else ax_nxt = sat32(64'(qv));
          end
          if (!sel_r) begin
            sel_nxt = 1'b1;
            state_nxt = ST_SMUL;
          end else state_nxt = phase_r ? ST_LIMR : ST_DIFF;
        end
      end
      ST_PDGO: state_nxt = ST_PDW;
      ST_PDW: begin
        if (div_done) begin
          if (sel_r) ay_nxt = (cfg.update_period == '0) ? '0 : sat32(sval);
          else ax_nxt = (cfg.update_period == '0) ? '0 : sat32(sval);
          if (!sel_r) begin
            sel_nxt = 1'b1;
            state_nxt = ST_PDGO;
          end else state_nxt = ST_LIMR;
        end
      end
      ST_DIFF: begin
        va_nxt = tx_r - x_r;
        vb_nxt = ty_r - y_r;
        phase_nxt = 1'b1;
        state_nxt = ST_LIMT;
      end
      ST_LIMT: begin
        lim_nxt = (64'(cfg.max_accel) * 64'(cfg.update_period)) >> FRAC_BITS;
        state_nxt = ST_VSH;
      end
      ST_LIMR: begin
        lim_nxt = (64'(cfg.max_turn_accel) * 64'(cfg.update_period)) >> FRAC_BITS;
        va_nxt = tt_r - mt_r;
        sel_nxt = 1'b0;
        state_nxt = ST_TURN;
      end
      ST_TURN: begin
        if (64'(v_abs) > lim_r) begin
          at_nxt = va_r[VW-1] ? -$signed({1'b0, cfg.max_turn_accel})
                              : $signed({1'b0, cfg.max_turn_accel});
          state_nxt = ST_DONE;
        end else state_nxt = ST_TDGO;
      end
      ST_TDGO: state_nxt = ST_TDW;
      ST_TDW: begin
        if (div_done) begin
          at_nxt = (cfg.update_period == '0) ? '0 : sat32(sval);
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    x_r <= x_nxt;   y_r <= y_nxt;   z_r <= z_nxt;
    tx_r <= tx_nxt; ty_r <= ty_nxt; tt_r <= tt_nxt; mt_r <= mt_nxt;
    va_r <= va_nxt; vb_r <= vb_nxt;
    acc_r <= acc_nxt; lim_r <= lim_nxt;
    as_r <= as_nxt; bs_r <= bs_nxt; s_r <= s_nxt; n_r <= n_nxt;
    phase_r <= phase_nxt; sel_r <= sel_nxt;
    flat_r <= flat_nxt; chip_r <= chip_nxt;
    ax_r <= ax_nxt; ay_r <= ay_nxt; at_r <= at_nxt;
    if (state_r == ST_DONE) begin
      ox_r <= ax_r; oy_r <= ay_r; ot_r <= at_r;
      of_r <= flat_r; oc_r <= chip_r;
    end
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= (state_r == ST_DONE);
    end
  end

  assign out_valid      = ov_r;
  assign out_accel_x    = ox_r;
  assign out_accel_y    = oy_r;
  assign out_accel_turn = ot_r;
  assign out_kick_flat  = of_r;
  assign out_kick_chip  = oc_r;

  a_kick_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_kick_flat && out_kick_chip))
    else $error("flat and chip kick both set");
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> state_r == ST_MOD)
    else $error("item popped without starting work");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_SDW || state_r == ST_PDW || state_r == ST_TDW))
    else $error("divider finished outside a wait state");
endmodule

// ----- hdl/velocity_command_accel_limiter.sv -----
`timescale 1ns / 1ps
// Channel   Handshake          Payload
// input     start / busy       in_target_*, in_measured_*, in_heading, in_*_trigger
// result    out_valid strobe   out_accel_x/y/turn, out_kick_flat, out_kick_chip
// config    cfg_we             cfg_index, cfg_wdata (31 bits)
//
// An item occupies the back end for the heading wrap and the 30 CORDIC steps, a serial
// square root per vector, and two to five passes of the serial 64-step divider; the
// result strobe follows in the cycle after the back end finishes.
// A four-deep queue takes items while the back end works; busy is high only when full.
// Reset (synchronous, rst_n low) empties the queue and loads the default registers.
// Results appear for one cycle; the receiver cannot stall.
module velocity_command_accel_limiter #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_target_vx,
  input  logic signed [31:0] in_target_vy,
  input  logic signed [31:0] in_target_turn,
  input  logic signed [31:0] in_measured_vx,
  input  logic signed [31:0] in_measured_vy,
  input  logic signed [31:0] in_measured_turn,
  input  logic signed [18:0] in_heading,
  input  logic signed [15:0] in_flat_trigger,
  input  logic signed [15:0] in_chip_trigger,
  output logic               out_valid,
  output logic signed [31:0] out_accel_x,
  output logic signed [31:0] out_accel_y,
  output logic signed [31:0] out_accel_turn,
  output logic               out_kick_flat,
  output logic               out_kick_chip,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_wdata
);
  import vcal_pkg::*;

  vcal_cfg_t  cfg_r;
  vcal_item_t q_item;
  logic       q_valid, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_speed      <= '0;
      cfg_r.max_turn_rate  <= '0;
      cfg_r.max_accel      <= '0;
      cfg_r.max_turn_accel <= '0;
      cfg_r.update_period  <= 17'd1092;
      cfg_r.kick_threshold <= 15'd16384;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_SPEED:      cfg_r.max_speed      <= cfg_wdata;
        CFG_MAX_TURN_RATE:  cfg_r.max_turn_rate  <= cfg_wdata;
        CFG_MAX_ACCEL:      cfg_r.max_accel      <= cfg_wdata;
        CFG_MAX_TURN_ACCEL: cfg_r.max_turn_accel <= cfg_wdata;
        CFG_UPDATE_PERIOD:  cfg_r.update_period  <= cfg_wdata[16:0];
        CFG_KICK_THRESHOLD: cfg_r.kick_threshold <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  vcal_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_target_vx(in_target_vx), .in_target_vy(in_target_vy),
    .in_target_turn(in_target_turn), .in_measured_vx(in_measured_vx),
    .in_measured_vy(in_measured_vy), .in_measured_turn(in_measured_turn),
    .in_heading(in_heading), .in_flat_trigger(in_flat_trigger),
    .in_chip_trigger(in_chip_trigger), .kick_threshold(cfg_r.kick_threshold),
    .pop(pop), .q_valid(q_valid), .q_item(q_item)
  );

  vcal_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_valid(q_valid), .q_item(q_item),
    .pop(pop), .out_valid(out_valid), .out_accel_x(out_accel_x),
    .out_accel_y(out_accel_y), .out_accel_turn(out_accel_turn),
    .out_kick_flat(out_kick_flat), .out_kick_chip(out_kick_chip)
  );
endmodule
